// ===== hw/rtl/rse_pkg.sv =====
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, constants and GF(256) helpers for the Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

	// Largest number of parity bytes the generator table supports.
	localparam int MaxParity = 32;

	// Field polynomial x^8+x^4+x^3+x^2+1.
	localparam logic [8:0] FieldPoly = 9'h11D;

	// Message length after reset.
	localparam logic [7:0] MsgLenReset = 8'd188;

	typedef logic [MaxParity:0][7:0] gen_arr_t;

	// Commands from the control logic to the parity register.
	typedef struct packed {
		logic step;   // clock one message byte into the register
		logic shift;  // move parity up by one byte, zero fills the bottom
	} lfsr_ctrl_t;

	// GF(256) multiply; with one constant operand it reduces to an XOR net.
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] aa;
		logic [7:0] r;
		aa = {1'b0, a};
		r  = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				r = r ^ aa[7:0];
			end
			aa = {aa[7:0], 1'b0};
			if (aa[8]) begin
				aa = aa ^ FieldPoly;
			end
		end
		return r;
	endfunction

	// Coefficients of the product of (x + alpha^i), i = 0 .. n-1.
	// Evaluated at elaboration only.
	function automatic gen_arr_t gen_poly(input int n);
		gen_arr_t g;
		logic [7:0] root;
		g    = '0;
		g[0] = 8'd1;
		root = 8'd1;
		for (int i = 0; i < MaxParity; i++) begin
			if (i < n) begin
				for (int k = MaxParity; k >= 1; k--) begin
					if (k <= i + 1) begin
						g[k] = g[k-1] ^ gf_mul(g[k], root);
					end
				end
				g[0] = gf_mul(g[0], root);
				root = gf_mul(root, 8'd2);
			end
		end
		return g;
	endfunction

endpackage

// ===== hw/rtl/rse_lfsr.sv =====
// ----------------------------------------------------------------------------
// rse_lfsr
// Parity register of the encoder: takes one message byte per step, and
// shifts the finished parity out from the top byte during a parity burst.
// ----------------------------------------------------------------------------
module rse_lfsr #(
	parameter int PARITY_BYTES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rse_pkg::lfsr_ctrl_t ctrl,
	input  logic [7:0]         data_byte,
	output logic [7:0]         top_byte
);
	import rse_pkg::*;

	localparam gen_arr_t GenPoly = gen_poly(PARITY_BYTES);

	logic [PARITY_BYTES-1:0][7:0] parity_q;
	logic [7:0]                   fb;

	assign top_byte = parity_q[PARITY_BYTES-1];
	assign fb       = data_byte ^ parity_q[PARITY_BYTES-1];

	// Shifting in zeros during the burst also leaves the register clear
	// for the next codeword once the last parity byte has gone out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= '0;
		end else if (ctrl.step) begin
			parity_q[0] <= gf_mul(GenPoly[0], fb);
			for (int j = 1; j < PARITY_BYTES; j++) begin
				parity_q[j] <= parity_q[j-1] ^ gf_mul(GenPoly[j], fb);
			end
		end else if (ctrl.shift) begin
			parity_q[0] <= '0;
			for (int j = 1; j < PARITY_BYTES; j++) begin
				parity_q[j] <= parity_q[j-1];
			end
		end
	end

endmodule

// ===== hw/rtl/reed_solomon_systematic_encoder_top.sv =====
// ----------------------------------------------------------------------------
// reed_solomon_systematic_encoder_top
// Systematic RS encoder over GF(256): message words pass through, followed
// by the parity burst, highest parity byte first.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Signals                        Contents
// s_       in   s_tvalid s_tready s_tdata[7:0] data_byte
// m_       out  m_tvalid m_tready m_tdata[7:0] code_byte
//                          m_tuser m_tlast     is_parity, last of codeword
// cfg_     in   cfg_we cfg_wdata[7:0]          msg_len
//
// Each message word is registered in the input and then the output register;
// message words stream at one per cycle while m_tready is high and no parity
// burst runs. The word that ends a codeword is followed by PARITY_BYTES
// parity words, one per cycle while m_tready is high, while the input
// register holds at most one waiting word. Reset clears the parity register,
// the byte count and both register stages, and loads msg_len with 188.
// A stall on m_tready holds the output word and backs up into s_tready.
// ----------------------------------------------------------------------------
module reed_solomon_systematic_encoder_top #(
	parameter int PARITY_BYTES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// Input stream.
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	// Output stream.
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] code_byte
	output logic       m_tuser,   // [0] is_parity
	output logic       m_tlast,
	// Configuration.
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);
	import rse_pkg::*;

	localparam int CntW = $clog2(PARITY_BYTES + 1);

	// Length register.
	logic [7:0]      msg_len_q;

	// Input register stage.
	logic            valid_s1;
	logic [7:0]      data_s1;

	// Codeword control.
	logic [7:0]      byte_count_q;
	logic [CntW-1:0] burst_left_q;

	// Output register.
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            out_par_q;
	logic            out_last_q;

	logic            out_free;
	logic            in_burst;
	logic            take_msg;
	logic            take_par;
	logic [7:0]      limit;
	logic [7:0]      count_next;
	logic            word_ends;
	logic [7:0]      top_byte;
	lfsr_ctrl_t      lfsr_ctrl;

	// The output register can take a new word when it is empty or when its
	// current word leaves at this edge.
	assign out_free = !out_valid_q || m_tready;
	assign in_burst = (burst_left_q != '0);

	// Message words wait in the input stage while parity is being sent.
	assign take_msg = valid_s1 && !in_burst && out_free;
	assign take_par = in_burst && out_free;

	assign s_tready = !valid_s1 || take_msg;

	// A length of zero acts as one. The count wraps at 8 bits, and a wrap to
	// zero also ends the codeword.
	assign limit      = (msg_len_q == 8'd0) ? 8'd1 : msg_len_q;
	assign count_next = byte_count_q + 8'd1;
	assign word_ends  = (count_next >= limit) || (count_next == 8'd0);

	assign lfsr_ctrl.step  = take_msg;
	assign lfsr_ctrl.shift = take_par;

	rse_lfsr #(
		.PARITY_BYTES(PARITY_BYTES)
	) u_lfsr (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (lfsr_ctrl),
		.data_byte (data_s1),
		.top_byte  (top_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q <= MsgLenReset;
		end else if (cfg_we) begin
			msg_len_q <= cfg_wdata;
		end
	end

	// Input stage: one word deep, refilled in the cycle it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
		end
	end

	// Byte count and parity burst counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			burst_left_q <= '0;
		end else if (take_msg) begin
			if (word_ends) begin
				byte_count_q <= '0;
				burst_left_q <= CntW'(PARITY_BYTES);
			end else begin
				byte_count_q <= count_next;
			end
		end else if (take_par) begin
			burst_left_q <= burst_left_q - CntW'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= take_msg || take_par;
		end
	end

	always_ff @(posedge clk) begin
		if (take_msg) begin
			out_byte_q <= data_s1;
			out_par_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else if (take_par) begin
			out_byte_q <= top_byte;
			out_par_q  <= 1'b1;
			out_last_q <= (burst_left_q == CntW'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_par_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== hw/rtl/rse_checker.sv =====
// ----------------------------------------------------------------------------
// rse_checker
// Port-level checks of the encoder's output stream, bound to the top level.
// ----------------------------------------------------------------------------
module rse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// Only a parity word can close a codeword.
	a_last_is_parity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("last word is not a parity word");

	// Once a parity burst has begun, the next parity word follows directly.
	a_burst_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser && !m_tlast |=> m_tvalid && m_tuser)
		else $error("parity burst interrupted");

	// A stalled word holds its value and flags.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

endmodule

bind reed_solomon_systematic_encoder_top rse_checker u_rse_checker (.*);

// ===== test/reed_solomon_systematic_encoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reed_solomon_systematic_encoder_top_tb
// Self-checking bench for the RS(n, n-16) encoder: directed rows first, then
// random codewords at many lengths, each output word checked in order against
// a bit-true parity model kept inside the bench.
// ----------------------------------------------------------------------------
module reed_solomon_systematic_encoder_top_tb;

	localparam int ParityBytes = 16;
	// Cycles without any accepted word before the run is declared hung.
	localparam int StallLimit  = 2000;
	// Length of the one long back-pressure hold on the output side.
	localparam int LongHold    = 300;
	// Words offered while that hold is in force.
	localparam int HoldItems   = 12;
	// Random words sent at small codeword lengths.
	localparam int SmallItems  = 90;
	localparam int NumRows     = 18;
	// Low byte of the field polynomial x^8+x^4+x^3+x^2+1.
	localparam logic [7:0] FieldLow = 8'h1D;

	// One word on the output stream.
	typedef struct packed {
		logic [7:0] code;
		logic       parity;
		logic       last;
	} code_word_t;

	// How a directed row gets its expected words: from the parity model,
	// as a lone message word, or as a codeword of zeros with zero parity.
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_MSG_ONLY,
		ROW_ZERO_CW
	} row_kind_t;

	typedef struct packed {
		logic       wr;
		logic [7:0] len;
		logic [7:0] data;
		row_kind_t  kind;
	} dir_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = 8'h00;   // [7:0] data_byte
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;             // [7:0] code_byte
	logic       m_tuser;             // [0] is_parity
	logic       m_tlast;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	// Parity model state: generator coefficients, the LFSR, the number of
	// message bytes taken in the current codeword and the configured length.
	logic [7:0] gen_coef [ParityBytes+1];
	logic [7:0] lfsr [ParityBytes];
	logic [7:0] taken;
	logic [7:0] cw_len;

	// Words caused by the last byte, and all words still owed by the DUT.
	code_word_t step_words [$];
	code_word_t owed_words [$];

	dir_row_t rows [NumRows];

	int mismatches   = 0;
	int results_seen = 0;
	int idle_cycles  = 0;
	int rx_wait      = 0;
	bit rx_quiet     = 1'b0;
	bit tx_quiet     = 1'b0;
	// The stimulus asks for the long hold; the ready driver starts it once.
	bit hold_req     = 1'b0;
	bit hold_taken   = 1'b0;

	reed_solomon_systematic_encoder_top #(
		.PARITY_BYTES(ParityBytes)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Shift-and-add multiply in GF(256).
	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x   = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = x[7] ? ((x << 1) ^ FieldLow) : (x << 1);
		end
		return acc;
	endfunction

	// Clocks one message byte into the parity model. The message word always
	// comes first; the byte that completes the codeword adds the parity burst,
	// highest register first, and clears the LFSR and the count.
	function automatic void encode_byte(input logic [7:0] b);
		logic [7:0] fb;
		logic [7:0] lim;
		step_words.delete();
		step_words.push_back(code_word_t'{b, 1'b0, 1'b0});
		fb = b ^ lfsr[ParityBytes-1];
		for (int j = ParityBytes - 1; j > 0; j--) begin
			lfsr[j] = lfsr[j-1] ^ gf_times(gen_coef[j], fb);
		end
		lfsr[0] = gf_times(gen_coef[0], fb);
		// A length of zero behaves as a length of one.
		lim   = (cw_len == 8'd0) ? 8'd1 : cw_len;
		taken = taken + 8'd1;
		// Reaching or passing the length ends the codeword; this also covers
		// a length lowered below the count in the middle of a codeword.
		if (taken >= lim || taken == 8'd0) begin
			for (int j = ParityBytes - 1; j >= 0; j--) begin
				step_words.push_back(code_word_t'{lfsr[j], 1'b1, j == 0});
			end
			foreach (lfsr[j]) begin
				lfsr[j] = 8'h00;
			end
			taken = 8'h00;
		end
	endfunction

	// Writes msg_len once the DUT has drained every owed word.
	task automatic write_len(input logic [7:0] v);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (owed_words.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		cw_len = v;
	endtask

	// Offers one message byte after a random gap, waits for the handshake,
	// and records the words it must cause.
	task automatic send_item(input logic [7:0] b, input row_kind_t kind);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		do @(posedge clk); while (!s_tready);
		// The model always runs so its state stays in step with the DUT.
		encode_byte(b);
		if (kind == ROW_PREDICT) begin
			foreach (step_words[i]) begin
				owed_words.push_back(step_words[i]);
			end
		end else begin
			owed_words.push_back(code_word_t'{b, 1'b0, 1'b0});
			if (kind == ROW_ZERO_CW) begin
				for (int i = 0; i < ParityBytes; i++) begin
					owed_words.push_back(code_word_t'{8'h00, 1'b1, i == ParityBytes - 1});
				end
			end
		end
	endtask

	// Output side ready: low for the number of cycles the monitor asked for
	// after each accepted word, high otherwise. The one long hold is loaded
	// here when the stimulus asks for it.
	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			rx_wait    = LongHold;
		end
		if (rx_wait > 0) begin
			m_tready = 1'b0;
			rx_wait  = rx_wait - 1;
		end else begin
			m_tready = 1'b1;
		end
	end

	// Monitor and watchdog. Every accepted output word is compared with the
	// oldest owed word. The watchdog restarts on any handshake on either side.
	always @(posedge clk) begin : monitor
		code_word_t got;
		code_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			idle_cycles = 0;
			got = code_word_t'{m_tdata, m_tuser, m_tlast};
			if (owed_words.size() == 0) begin
				$display("%0t: unexpected word code=%02h parity=%0b last=%0b",
					$time, got.code, got.parity, got.last);
				mismatches++;
			end else begin
				want = owed_words.pop_front();
				if (got.code != want.code) begin
					$display("%0t: code_byte expected %02h actual %02h",
						$time, want.code, got.code);
					mismatches++;
				end
				if (got.parity != want.parity) begin
					$display("%0t: is_parity expected %0b actual %0b",
						$time, want.parity, got.parity);
					mismatches++;
				end
				if (got.last != want.last) begin
					$display("%0t: last expected %0b actual %0b",
						$time, want.last, got.last);
					mismatches++;
				end
			end
			results_seen++;
			if (results_seen % 40 == 0) begin
				rx_quiet = ($urandom_range(0, 2) == 0);
			end
			rx_wait = rx_quiet ? 0 : $urandom_range(0, 11);
		end else if (arst_n && s_tvalid && s_tready) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("%0t: no word moved for %0d cycles", $time, StallLimit);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [7:0] root;
		logic [7:0] len;
		logic [7:0] eff;
		logic [7:0] b;
		int n;
		int small_done;

		// Generator: product of (x + alpha^i), coefficient k of x^k.
		foreach (gen_coef[k]) begin
			gen_coef[k] = 8'h00;
		end
		gen_coef[0] = 8'h01;
		root = 8'h01;
		for (int i = 0; i < ParityBytes; i++) begin
			for (int k = i + 1; k > 0; k--) begin
				gen_coef[k] = gen_coef[k-1] ^ gf_times(gen_coef[k], root);
			end
			gen_coef[0] = gf_times(gen_coef[0], root);
			root = gf_times(root, 8'h02);
		end
		foreach (lfsr[j]) begin
			lfsr[j] = 8'h00;
		end
		taken  = 8'h00;
		cw_len = rse_pkg::MsgLenReset;

		// Directed rows: write flag, length, data byte, source of expectation.
		rows = '{
			// Right after reset the length is 188, so the first byte only
			// passes through.
			'{1'b0, 8'd0,   8'h00, ROW_MSG_ONLY},
			// The count already meets the new length: the next byte ends an
			// all-zero codeword.
			'{1'b1, 8'd1,   8'h00, ROW_ZERO_CW},
			'{1'b0, 8'd0,   8'hFF, ROW_PREDICT},
			'{1'b0, 8'd0,   8'h01, ROW_PREDICT},
			'{1'b0, 8'd0,   8'h80, ROW_PREDICT},
			// Length zero behaves as one.
			'{1'b1, 8'd0,   8'h00, ROW_ZERO_CW},
			'{1'b0, 8'd0,   8'hA5, ROW_PREDICT},
			'{1'b1, 8'd3,   8'h00, ROW_MSG_ONLY},
			'{1'b0, 8'd0,   8'h00, ROW_MSG_ONLY},
			'{1'b0, 8'd0,   8'h00, ROW_ZERO_CW},
			'{1'b0, 8'd0,   8'h12, ROW_PREDICT},
			'{1'b0, 8'd0,   8'hFF, ROW_PREDICT},
			// Length lowered below the count mid-codeword.
			'{1'b1, 8'd1,   8'h34, ROW_PREDICT},
			'{1'b1, 8'd5,   8'h55, ROW_PREDICT},
			'{1'b0, 8'd0,   8'hAA, ROW_PREDICT},
			// Length lowered to exactly the count mid-codeword.
			'{1'b1, 8'd2,   8'h0F, ROW_PREDICT},
			'{1'b1, 8'd2,   8'hFF, ROW_PREDICT},
			'{1'b0, 8'd0,   8'h00, ROW_PREDICT}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[r]) begin
			if (rows[r].wr) begin
				write_len(rows[r].len);
			end
			send_item(rows[r].data, rows[r].kind);
		end

		// One long hold on the output side while a codeword keeps coming in,
		// so both register stages fill and the input side stalls.
		write_len(8'd12);
		hold_req = 1'b1;
		repeat (HoldItems) begin
			send_item(8'($urandom_range(0, 255)), ROW_PREDICT);
		end

		// Random phases. Two carry the longest lengths with a partial
		// codeword that the next length change cuts into; the rest use short
		// lengths with whole codewords and, now and then, a partial one.
		small_done = 0;
		for (int p = 0; p < 6 || small_done < SmallItems; p++) begin
			if (p == 2) begin
				len = 8'd255;
			end else if (p == 5) begin
				len = 8'd239;
			end else if ($urandom_range(0, 7) == 0) begin
				len = 8'd0;
			end else begin
				len = 8'($urandom_range(1, 24));
			end
			write_len(len);
			eff = (len == 8'd0) ? 8'd1 : len;
			if (p == 2 || p == 5) begin
				n = $urandom_range(4, 12);
			end else begin
				n = eff * $urandom_range(1, 3);
				if (eff > 1 && $urandom_range(0, 3) == 0) begin
					n += $urandom_range(1, eff - 1);
				end
				small_done += n;
			end
			tx_quiet = ($urandom_range(0, 3) == 0);
			repeat (n) begin
				case ($urandom_range(0, 7))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				send_item(b, ROW_PREDICT);
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (owed_words.size() != 0) begin
			@(posedge clk);
		end
		// Let any stray word show up before the verdict.
		repeat (ParityBytes + 8) @(posedge clk);
		if (mismatches == 0 && owed_words.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
